// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expects i_clk and i_rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define MD5SH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("md5sh: same-cycle check failed");

// Next-cycle implication
`define MD5SH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("md5sh: next-cycle check failed");

`endif

// File: hw/rtl/md5sh_pkg.sv
package md5sh_pkg;

    // Default depth of the word queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // MD5 chaining initial values
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_RND = 6'd63;
    localparam logic [2:0] LAST_LEN = 3'd7;

    // Queue entry: a message byte or a finish marker
    typedef struct packed {
        logic       fin;
        logic [7:0] data;
    } t_item;

    // Block buffer access: one write and one read port
    typedef struct packed {
        logic        we;
        logic [3:0]  waddr;
        logic [31:0] wdata;
        logic [3:0]  raddr;
    } t_ram_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_PRE,
        S_ROUND,
        S_FOLD,
        S_EMIT
    } t_bstate;

    typedef enum logic [1:0] {
        PH_MARK,
        PH_ZERO,
        PH_LEN,
        PH_DONE
    } t_pad_ph;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Rotate amounts, indexed by {phase, round[1:0]}
    localparam logic [4:0] ROT_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word used in round r
    function automatic logic [3:0] msg_index(input logic [5:0] r);
        logic [3:0] x;
        logic [3:0] g;
        x = r[3:0];
        unique case (r[5:4])
            2'd0: g = x;
            2'd1: g = (x << 2) + x + 4'd1;
            2'd2: g = (x << 1) + x + 4'd5;
            2'd3: g = (x << 3) - x;
        endcase
        return g;
    endfunction

    // Round boolean function
    function automatic logic [31:0] round_f(input logic [1:0] ph, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (ph)
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (d & b) | (~d & c);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
        logic [63:0] t;
        t = {v, v} << s;
        return t[63:32];
    endfunction

endpackage

// File: hw/rtl/md5sh_ram.sv
module md5sh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/md5sh_front.sv
`include "assert_macros.svh"

module md5sh_front import md5sh_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0] i_s_axis_tuser,   // [0] op
    output logic       o_item_valid,
    input  logic       i_item_ready,
    output t_item      o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_item            r_q [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;
    t_item            in_item;

    // Classify the incoming word
    always_comb begin
        in_item.fin  = i_s_axis_tuser[0];
        in_item.data = i_s_axis_tdata;
    end

    assign o_s_axis_tready = (r_count != CNT_FULL);
    assign o_item_valid    = (r_count != '0);
    assign o_item          = r_q[r_rd];
    assign push            = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = o_item_valid && i_item_ready;

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= in_item;
        end
    end

    // Queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `MD5SH_ASSERT_NEXT(a_full_holds, (r_count == CNT_FULL) && !pop, r_count == CNT_FULL)

endmodule

// File: hw/rtl/md5sh_back.sv
`include "assert_macros.svh"

module md5sh_back import md5sh_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_item_valid,
    output logic         o_item_ready,
    input  t_item        i_item,
    output t_ram_req     o_ram,
    input  logic [31:0]  i_ram_rdata,
    output logic         o_dig_valid,
    input  logic         i_dig_ready,
    output logic [127:0] o_digest
);

    t_bstate     r_state, n_state;
    t_pad_ph     r_ph, n_ph;
    logic [5:0]  r_fill, n_fill;
    logic [23:0] r_word, n_word;
    logic [60:0] r_cnt, n_cnt;
    logic [63:0] r_len, n_len;
    logic [2:0]  r_lcnt, n_lcnt;
    logic        r_fin, n_fin;
    logic [5:0]  r_round, n_round;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] n_a, n_b, n_c, n_d;
    logic [31:0] r_ha, r_hb, r_hc, r_hd;
    logic [31:0] n_ha, n_hb, n_hc, n_hd;

    logic        absorb;
    logic [7:0]  abs_byte;
    logic [31:0] rnd_sum, rnd_t;
    logic [5:0]  rnd_next;

    // One MD5 round
    assign rnd_next = r_round + 6'd1;
    assign rnd_sum  = r_a + round_f(r_round[5:4], r_b, r_c, r_d) + SINE_K[r_round] + i_ram_rdata;
    assign rnd_t    = r_b + rotl32(rnd_sum, ROT_S[{r_round[5:4], r_round[1:0]}]);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.fin) begin
                        n_state = S_PAD;
                    end else if (r_fill == LAST_POS) begin
                        n_state = S_PRE;
                    end
                end
            end
            S_PAD: begin
                if (absorb && r_fill == LAST_POS) begin
                    n_state = S_PRE;
                end
            end
            S_PRE:   n_state = S_ROUND;
            S_ROUND: begin
                if (r_round == LAST_RND) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD: begin
                if (!r_fin) begin
                    n_state = S_IDLE;
                end else if (r_ph == PH_DONE) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_EMIT: begin
                if (i_dig_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Byte source, handshakes and buffer port
    always_comb begin
        absorb       = 1'b0;
        abs_byte     = i_item.data;
        o_item_ready = 1'b0;
        o_dig_valid  = 1'b0;
        o_ram.raddr  = msg_index(rnd_next);
        unique case (r_state)
            S_IDLE: begin
                o_item_ready = 1'b1;
                absorb       = i_item_valid && !i_item.fin;
            end
            S_PAD: begin
                unique case (r_ph)
                    PH_MARK: begin
                        absorb   = 1'b1;
                        abs_byte = PAD_MARK;
                    end
                    PH_ZERO: begin
                        absorb   = (r_fill != LEN_POS);
                        abs_byte = 8'h00;
                    end
                    PH_LEN: begin
                        absorb   = 1'b1;
                        abs_byte = r_len[7:0];
                    end
                    PH_DONE: absorb = 1'b0;
                endcase
            end
            S_PRE:   o_ram.raddr = msg_index(6'd0);
            S_EMIT:  o_dig_valid = 1'b1;
            default: absorb = 1'b0;
        endcase
        o_ram.we    = absorb && (r_fill[1:0] == 2'd3);
        o_ram.waddr = r_fill[5:2];
        o_ram.wdata = {abs_byte, r_word};
    end

    // Datapath next values
    always_comb begin
        n_ph    = r_ph;
        n_fill  = r_fill;
        n_word  = r_word;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_lcnt  = r_lcnt;
        n_fin   = r_fin;
        n_round = r_round;
        {n_a, n_b, n_c, n_d}     = {r_a, r_b, r_c, r_d};
        {n_ha, n_hb, n_hc, n_hd} = {r_ha, r_hb, r_hc, r_hd};

        // gather bytes into the pending word
        if (absorb) begin
            n_fill = r_fill + 6'd1;
            unique case (r_fill[1:0])
                2'd0: n_word[7:0]   = abs_byte;
                2'd1: n_word[15:8]  = abs_byte;
                2'd2: n_word[23:16] = abs_byte;
                2'd3: n_word        = r_word;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.fin) begin
                        n_fin  = 1'b1;
                        n_ph   = PH_MARK;
                        n_lcnt = 3'd0;
                        n_len  = {r_cnt, 3'b000};
                    end else begin
                        n_cnt = r_cnt + 61'd1;
                    end
                end
            end
            S_PAD: begin
                unique case (r_ph)
                    PH_MARK: n_ph = PH_ZERO;
                    PH_ZERO: begin
                        if (r_fill == LEN_POS) begin
                            n_ph = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        n_len  = {8'h00, r_len[63:8]};
                        n_lcnt = r_lcnt + 3'd1;
                        if (r_lcnt == LAST_LEN) begin
                            n_ph = PH_DONE;
                        end
                    end
                    PH_DONE: n_ph = r_ph;
                endcase
            end
            S_PRE: begin
                n_round = 6'd0;
                {n_a, n_b, n_c, n_d} = {r_ha, r_hb, r_hc, r_hd};
            end
            S_ROUND: begin
                n_round = rnd_next;
                n_a     = r_d;
                n_b     = rnd_t;
                n_c     = r_b;
                n_d     = r_c;
            end
            S_FOLD: begin
                n_ha = r_ha + r_a;
                n_hb = r_hb + r_b;
                n_hc = r_hc + r_c;
                n_hd = r_hd + r_d;
            end
            S_EMIT: begin
                // digest handed over: start a fresh message
                if (i_dig_ready) begin
                    n_fin = 1'b0;
                    n_cnt = '0;
                    n_ha  = INIT_A;
                    n_hb  = INIT_B;
                    n_hc  = INIT_C;
                    n_hd  = INIT_D;
                end
            end
            default: n_fin = r_fin;
        endcase
    end

    // Control and chaining registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= PH_MARK;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_lcnt  <= '0;
            r_fin   <= 1'b0;
            r_round <= '0;
            r_ha    <= INIT_A;
            r_hb    <= INIT_B;
            r_hc    <= INIT_C;
            r_hd    <= INIT_D;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_fill  <= n_fill;
            r_cnt   <= n_cnt;
            r_lcnt  <= n_lcnt;
            r_fin   <= n_fin;
            r_round <= n_round;
            r_ha    <= n_ha;
            r_hb    <= n_hb;
            r_hc    <= n_hc;
            r_hd    <= n_hd;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_len  <= n_len;
        r_a    <= n_a;
        r_b    <= n_b;
        r_c    <= n_c;
        r_d    <= n_d;
    end

    assign o_digest = {r_hd, r_hc, r_hb, r_ha};

    `MD5SH_ASSERT_IMP(a_pre_block_full, r_state == S_PRE, r_fill == '0)
    `MD5SH_ASSERT_IMP(a_emit_padded, r_state == S_EMIT, r_ph == PH_DONE && r_fill == '0)
    `MD5SH_ASSERT_NEXT(a_round_run, r_state == S_ROUND && r_round != LAST_RND, r_state == S_ROUND)

endmodule

// File: hw/rtl/md5_stream_hasher_core.sv
// MD5 hasher over a byte stream.
// Input channel (s_axis): tuser[0] is the op, tdata[7:0] the message byte.
// op 0 appends the byte to the message; op 1 closes the message, pads it
// (0x80, zeros to byte 56, 64-bit bit length) and produces one digest.
// Output channel (m_axis): tdata carries the digest as four 32-bit words,
// bytes little-endian in each word, word a in the lowest bits.
// Throughput: bytes enter one per cycle while a block fills. Each full
// 64-byte block then occupies the compression engine for a prefetch step,
// 64 rounds at one round per cycle and a fold step; the single round adder
// chain and the one-read-port block buffer set this round rate.
// Bytes keep entering the input queue during compression until it fills.
// After a finish is taken, padding adds one byte per cycle (the 0x80 mark,
// zeros, a switch step, then the length bytes), with one or two compressions,
// before the digest is loaded into the output register.
// Reset (synchronous, active low) empties the queue and loads the MD5
// initial chaining values; no clearing pass is needed. After each digest
// the byte count and chaining values return to their reset values for the next message.
// If the receiver stalls, the digest is held in the output register and
// the engine waits; the input queue keeps accepting until it is full.
module md5_stream_hasher_core import md5sh_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]   i_s_axis_tuser,   // [0] op
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata    // [31:0] word_a, [63:32] word_b,
                                           // [95:64] word_c, [127:96] word_d
);

    t_item          item;
    logic           item_valid, item_ready;
    t_ram_req       ram_req;
    logic [31:0]    ram_rdata;
    logic           dig_valid, dig_ready;
    logic [127:0]   digest;
    logic           r_out_valid;
    logic [127:0]   r_out_data;

    md5sh_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_item_valid    (item_valid),
        .i_item_ready    (item_ready),
        .o_item          (item)
    );

    // Block buffer: sixteen little-endian message words
    md5sh_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_block_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    md5sh_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .o_item_ready (item_ready),
        .i_item       (item),
        .o_ram        (ram_req),
        .i_ram_rdata  (ram_rdata),
        .o_dig_valid  (dig_valid),
        .i_dig_ready  (dig_ready),
        .o_digest     (digest)
    );

    // Output register
    assign dig_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (dig_valid && dig_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dig_valid && dig_ready) begin
            r_out_data <= digest;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
